>>> design/ptw_pkg.sv
// Shared types, codes and helper functions for the page table walker.
// No dependencies; every other design file imports this package.
`default_nettype none

package ptw_pkg;

	// Fixed field widths of the block's channels.
	localparam int PAGE_W  = 44;
	localparam int MEM_W   = 45;
	localparam int VA_W    = 64;
	localparam int WVA_W   = 39;
	localparam int ENTRY_W = 10;
	localparam int PA_W    = 56;
	localparam int FLAGS_W = 8;
	localparam int LEVEL_W = 2;
	localparam int OFS_W   = 12;

	// Stream data widths, padded to whole bytes.
	localparam int S_TDATA_W = 120;
	localparam int M_TDATA_W = 120;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = MEM_W;

	localparam int PPN_BITS_DEF = 44;

	localparam logic [PAGE_W-1:0] ROOT_RESET = PAGE_W'(4096);
	localparam logic [MEM_W-1:0]  MEM_RESET  = MEM_W'(4096);

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WALK_MODE  = 2'd0,
		REG_ROOT_PAGE  = 2'd1,
		REG_MEM_PAGES  = 2'd2
	} reg_idx_t;

	typedef enum logic {
		OP_TRANSLATE = 1'b0,
		OP_RESPONSE  = 1'b1
	} op_t;

	typedef enum logic {
		KIND_REQ  = 1'b0,
		KIND_DONE = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		FLT_OK         = 3'd0,
		FLT_NO_MEM     = 3'd1,
		FLT_SIGN_EXT   = 3'd2,
		FLT_INVALID    = 3'd3,
		FLT_MISALIGNED = 3'd4,
		FLT_BEYOND_MEM = 3'd5,
		FLT_NO_LEAF    = 3'd6,
		FLT_UNEXPECTED = 3'd7
	} fault_t;

	localparam logic [LEVEL_W-1:0] LVL_0 = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_1 = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_2 = 2'd2;

	// PTE flag bit positions.
	localparam int FLAG_V = 0;

	typedef struct packed {
		logic               sv39;
		logic [PAGE_W-1:0]  root_page;
		logic [MEM_W-1:0]   mem_pages;
	} ptw_cfg_t;

	typedef struct packed {
		logic                busy;
		logic [WVA_W-1:0]    vaddr;
		logic [LEVEL_W-1:0]  level;
	} ptw_state_t;

	typedef struct packed {
		kind_t               kind;
		logic [PAGE_W-1:0]   req_table_page;
		logic [ENTRY_W-1:0]  req_entry;
		logic [PA_W-1:0]     phys_addr;
		fault_t              fault_code;
		logic [LEVEL_W-1:0]  end_level;
	} ptw_result_t;

	// Index of the PTE for a given level: 9-bit VPNs in Sv39, 10-bit in Sv32.
	function automatic logic [ENTRY_W-1:0] vpn_of(input logic [WVA_W-1:0] va,
			input logic sv39, input logic [LEVEL_W-1:0] level);
		logic [ENTRY_W-1:0] vpn;
		vpn = '0;
		if (sv39) begin
			case (level)
				LVL_0:   vpn = {1'b0, va[20:12]};
				LVL_1:   vpn = {1'b0, va[29:21]};
				LVL_2:   vpn = {1'b0, va[38:30]};
				default: vpn = '0;
			endcase
		end else begin
			if (level[0]) begin
				vpn = va[31:22];
			end else begin
				vpn = va[21:12];
			end
		end
		return vpn;
	endfunction

endpackage

`default_nettype wire

>>> design/ptw_cfg.sv
// Configuration register file of the page table walker.
// Depends on ptw_pkg for the register indexes and the configuration struct.
`default_nettype none

module ptw_cfg
	import ptw_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output ptw_cfg_t                   cfg
);

	ptw_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sv39      <= 1'b0;
			cfg_q.root_page <= ROOT_RESET;
			cfg_q.mem_pages <= MEM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WALK_MODE: cfg_q.sv39      <= cfg_data[0];
				REG_ROOT_PAGE: cfg_q.root_page <= cfg_data[PAGE_W-1:0];
				REG_MEM_PAGES: cfg_q.mem_pages <= cfg_data[MEM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> design/ptw_step.sv
// Decision logic for one item of the walker: result and next walk state.
// Depends on ptw_pkg for types, fault codes and the VPN helper.
`default_nettype none

module ptw_step
	import ptw_pkg::*;
#(
	parameter int PPN_BITS = PPN_BITS_DEF
) (
	input  wire logic               op,
	input  wire logic [VA_W-1:0]    virt_addr,
	input  wire logic [PAGE_W-1:0]  pte_page,
	input  wire logic [FLAGS_W-1:0] pte_flags,
	input  wire ptw_cfg_t           cfg,
	input  wire ptw_state_t         state,
	output ptw_result_t             res,
	output ptw_state_t              state_nxt
);

	logic [PPN_BITS-1:0]  ppn;
	logic [PPN_BITS-1:0]  base_pg;
	logic [PA_W-1:0]      pa;
	logic [LEVEL_W-1:0]   top_lvl;
	logic [LEVEL_W-1:0]   lvl_dn;
	logic [WVA_W-1:0]     new_va;
	logic                 sign_ok;
	logic                 misaligned;

	assign ppn      = pte_page[PPN_BITS-1:0];
	assign base_pg  = cfg.root_page[PPN_BITS-1:0];
	assign pa       = {PAGE_W'(ppn), state.vaddr[OFS_W-1:0]};
	assign top_lvl  = cfg.sv39 ? LVL_2 : LVL_1;
	assign lvl_dn   = state.level - LVL_1;
	assign new_va   = cfg.sv39 ? virt_addr[WVA_W-1:0] : WVA_W'(virt_addr[31:0]);
	assign sign_ok  = (virt_addr[VA_W-1:38] == '0) || (virt_addr[VA_W-1:38] == '1);

	// A superpage leaf needs every lower VPN of the address to be zero.
	assign misaligned =
		((state.level != LVL_0) && (vpn_of(state.vaddr, cfg.sv39, LVL_0) != '0)) ||
		(state.level[1] && (vpn_of(state.vaddr, cfg.sv39, LVL_1) != '0));

	always_comb begin
		state_nxt = state;
		res       = '0;
		res.kind  = KIND_DONE;
		if (op == OP_TRANSLATE) begin
			state_nxt.busy = 1'b0;
			if (cfg.mem_pages == '0) begin
				res.fault_code = FLT_NO_MEM;
				res.end_level  = top_lvl;
			end else if (cfg.sv39 && !sign_ok) begin
				res.fault_code = FLT_SIGN_EXT;
				res.end_level  = LVL_2;
			end else begin
				state_nxt.busy     = 1'b1;
				state_nxt.vaddr    = new_va;
				state_nxt.level    = top_lvl;
				res.kind           = KIND_REQ;
				res.req_table_page = PAGE_W'(base_pg);
				res.req_entry      = vpn_of(new_va, cfg.sv39, top_lvl);
				res.end_level      = top_lvl;
			end
		end else if (!state.busy) begin
			// A response with no walk running is reported and otherwise ignored.
			res.fault_code = FLT_UNEXPECTED;
			res.end_level  = LVL_0;
		end else begin
			state_nxt.busy = 1'b0;
			res.end_level  = state.level;
			if (!cfg.sv39 && state.level[1]) begin
				res.fault_code = FLT_UNEXPECTED;
			end else if (!pte_flags[FLAG_V]) begin
				res.fault_code = FLT_INVALID;
			end else if (!cfg.sv39 && (state.level == LVL_0)) begin
				res.phys_addr = pa;
			end else if (pte_flags[3:1] != '0) begin
				if (misaligned) begin
					res.fault_code = FLT_MISALIGNED;
				end else begin
					res.phys_addr = pa;
				end
			end else if (MEM_W'(ppn) >= cfg.mem_pages) begin
				res.fault_code = FLT_BEYOND_MEM;
			end else if (state.level == LVL_0) begin
				res.fault_code = FLT_NO_LEAF;
			end else begin
				state_nxt.busy     = 1'b1;
				state_nxt.level    = lvl_dn;
				res.kind           = KIND_REQ;
				res.req_table_page = PAGE_W'(ppn);
				res.req_entry      = vpn_of(state.vaddr, cfg.sv39, lvl_dn);
				res.end_level      = lvl_dn;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/page_table_walker_top.sv
// Top level of the Sv32/Sv39 page table walker: input register, walk state,
// result register. Depends on ptw_pkg, ptw_cfg and ptw_step.
//
// Usage. Items arrive on the slave stream (s_*). s_tuser carries the op:
// a translate request starts a new walk for the virtual address, and a PTE
// response carries the PPN and flags of the entry the walker asked for. For
// every accepted beat exactly one result beat leaves on the master stream
// (m_*): m_tuser is the kind, either a PTE read request (table page, entry
// index and level) to forward to memory, or a finished translation with the
// physical address, a fault code and the level where the walk ended. The
// memory side answers each request by sending the PTE back as a response.
//
// Timing. An accepted beat is registered in the input register, decided by
// one level of compare-and-select logic and written to the result register
// once that register is free or being emptied, and then shows on m_tvalid.
// The walk state is updated when the result is written, so one beat per
// cycle is sustained with no bubble between dependent items while m_tready
// stays high; the rate is set by the single input-to-result register path.
//
// Stalls. While m_tready is low the result register holds its beat; the
// input register can still take one more beat, after which s_tready drops
// until the result is taken. Nothing is dropped or repeated.
//
// Reset. arst_n clears both valid flags and the walk state (idle) and loads
// the configuration defaults: Sv32, root table page 4096, 4096 pages of
// memory. Configuration is written through cfg_we/cfg_index/cfg_data, only
// while the walker is idle; the user must ensure this, the block does not.
`default_nettype none

module page_table_walker_top
	import ptw_pkg::*;
#(
	parameter int PPN_BITS = PPN_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration write port.
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// Input stream.
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	// s_tdata from bit 0 up: virt_addr[63:0], pte_page[107:64],
	// pte_flags[115:108], zero padding[119:116].
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	// s_tuser: op[0].
	input  wire logic [0:0]            s_tuser,
	// Result stream.
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	// m_tdata from bit 0 up: req_table_page[43:0], req_entry[53:44],
	// phys_addr[109:54], fault_code[112:110], end_level[114:113],
	// zero padding[119:115].
	output      logic [M_TDATA_W-1:0]  m_tdata,
	// m_tuser: kind[0].
	output      logic [0:0]            m_tuser
);

	ptw_cfg_t    cfg;
	ptw_state_t  state_q;
	ptw_state_t  state_nxt;
	ptw_result_t res;
	ptw_result_t out_q;

	logic                 s1_valid_q;
	logic                 op_s1;
	logic [VA_W-1:0]      va_s1;
	logic [PAGE_W-1:0]    page_s1;
	logic [FLAGS_W-1:0]   flags_s1;
	logic                 out_valid_q;
	logic                 advance;
	logic                 in_beat;

	ptw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ptw_step #(
		.PPN_BITS (PPN_BITS)
	) u_step (
		.op        (op_s1),
		.virt_addr (va_s1),
		.pte_page  (page_s1),
		.pte_flags (flags_s1),
		.cfg       (cfg),
		.state     (state_q),
		.res       (res),
		.state_nxt (state_nxt)
	);

	// The registered beat moves on when the result register is free or is
	// being emptied in this cycle.
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !s1_valid_q || advance;
	assign in_beat  = s_tvalid && s_tready;

	// Input register; the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_beat) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_s1    <= s_tuser[0];
			va_s1    <= s_tdata[63:0];
			page_s1  <= s_tdata[107:64];
			flags_s1 <= s_tdata[115:108];
		end
	end

	// Walk state changes exactly when a beat's result is registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_valid_q && advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_q && advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tuser[0] = out_q.kind;
	assign m_tdata    = {5'b0, out_q.end_level, out_q.fault_code, out_q.phys_addr,
		out_q.req_entry, out_q.req_table_page};

	// A finished walk always leaves the walker idle.
	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && advance && (res.kind == KIND_DONE)) |=> !state_q.busy)
		else $error("walker still busy after a finished translation");

	// A read request leaves the walker busy at the level it asked for.
	a_req_level: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && advance && (res.kind == KIND_REQ)) |=>
		(state_q.busy && (state_q.level == out_q.end_level)))
		else $error("walk state does not match the issued request");

	// A faulted translation never reports an address.
	a_fault_no_pa: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.kind == KIND_DONE) && (out_q.fault_code != FLT_OK)) |->
		(out_q.phys_addr == '0))
		else $error("physical address reported with a fault");

	// A running walk is never at a level beyond the Sv39 root.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.busy |-> (state_q.level != 2'd3))
		else $error("walk level out of range");

endmodule

`default_nettype wire

>>> tb/tb_page_table_walker_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for page_table_walker_top: drives translate and PTE beats,
// predicts every result beat and compares it field by field on the result stream.
// Depends on ptw_pkg and the page_table_walker_top RTL only.

module tb_page_table_walker_top;
	import ptw_pkg::*;

	// If this many cycles go by with no beat accepted on either stream, the run
	// is declared hung. The longest legal quiet stretch is the forced
	// back-pressure window plus a short drain, so this is a wide margin.
	localparam int STALL_LIMIT = 4000;
	// Length of the forced back-pressure window on the result stream.
	localparam int HOLD_CYCLES = 64;

	// One input beat as the walker sees it.
	typedef struct {
		op_t               op;
		logic [VA_W-1:0]   va;
		logic [PAGE_W-1:0] page;
		logic [FLAGS_W-1:0] flags;
	} walk_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [0:0]            m_tuser;

	page_table_walker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Beats waiting to be offered, and result beats predicted but not yet seen.
	walk_item_t  walk_items[$];
	ptw_result_t expected_results[$];
	walk_item_t  on_wire;
	int          queued_count = 0;
	int          mismatches = 0;

	// Idle and stall rates in percent; the stimulus process changes them per phase.
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	// Toggling hold_req asks the receiver for one long back-pressure window.
	logic hold_req = 1'b0;
	logic hold_ack = 1'b0;
	int   hold_left = 0;

	int stuck_cycles = 0;

	// Shadow of the walker's registers and walk state. The configuration copy
	// is updated when a register write is issued, with both streams drained
	// though a walk may be running, so it always matches what the block uses.
	logic               pred_sv39 = 1'b0;
	logic [PAGE_W-1:0]  pred_root = ROOT_RESET;
	logic [MEM_W-1:0]   pred_mem = MEM_RESET;
	logic               pred_busy = 1'b0;
	logic [WVA_W-1:0]   pred_va = '0;
	logic [LEVEL_W-1:0] pred_level = LVL_0;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// PTE index for a level: 9-bit VPN fields in Sv39, 10-bit in Sv32.
	function automatic logic [ENTRY_W-1:0] vpn_index(input logic [WVA_W-1:0] va,
			input logic sv39, input logic [LEVEL_W-1:0] lvl);
		logic [WVA_W-1:0] shifted;
		if (sv39) begin
			shifted = va >> (12 + 9 * lvl);
			return ENTRY_W'(shifted & 39'h1FF);
		end
		shifted = va >> (12 + 10 * lvl[0]);
		return ENTRY_W'(shifted & 39'h3FF);
	endfunction

	function automatic ptw_result_t finished(input fault_t code, input logic [LEVEL_W-1:0] lvl,
			input logic [PA_W-1:0] pa);
		ptw_result_t r;
		r = '0;
		r.kind = KIND_DONE;
		r.phys_addr = pa;
		r.fault_code = code;
		r.end_level = lvl;
		return r;
	endfunction

	function automatic ptw_result_t table_read(input logic [PAGE_W-1:0] page,
			input logic [ENTRY_W-1:0] entry, input logic [LEVEL_W-1:0] lvl);
		ptw_result_t r;
		r = '0;
		r.kind = KIND_REQ;
		r.req_table_page = page;
		r.req_entry = entry;
		r.fault_code = FLT_OK;
		r.end_level = lvl;
		return r;
	endfunction

	// Result beat caused by one accepted input beat; advances the shadow walk state.
	function automatic ptw_result_t predict_walk_step(input walk_item_t it);
		logic [LEVEL_W-1:0] top;
		logic [LEVEL_W-1:0] lvl;
		logic [PA_W-1:0]    pa;
		logic               misaligned;
		top = pred_sv39 ? LVL_2 : LVL_1;
		if (it.op == OP_TRANSLATE) begin
			// A new translate always abandons whatever walk was running.
			pred_busy = 1'b0;
			if (pred_mem == '0)
				return finished(FLT_NO_MEM, top, '0);
			if (pred_sv39) begin
				if (it.va[63:38] != '0 && it.va[63:38] != '1)
					return finished(FLT_SIGN_EXT, LVL_2, '0);
				pred_va = it.va[WVA_W-1:0];
			end else begin
				pred_va = {7'b0, it.va[31:0]};
			end
			pred_level = top;
			pred_busy = 1'b1;
			return table_read(pred_root, vpn_index(pred_va, pred_sv39, top), top);
		end
		// A response with no walk running is reported and otherwise ignored.
		if (!pred_busy)
			return finished(FLT_UNEXPECTED, LVL_0, '0);
		lvl = pred_level;
		pa = {it.page, pred_va[OFS_W-1:0]};
		// Mode switched to Sv32 while an Sv39 walk sat at its top level.
		if (!pred_sv39 && lvl > LVL_1) begin
			pred_busy = 1'b0;
			return finished(FLT_UNEXPECTED, lvl, '0);
		end
		if (!it.flags[FLAG_V]) begin
			pred_busy = 1'b0;
			return finished(FLT_INVALID, lvl, '0);
		end
		// The last Sv32 level takes any valid entry as the leaf.
		if (!pred_sv39 && lvl == LVL_0) begin
			pred_busy = 1'b0;
			return finished(FLT_OK, LVL_0, pa);
		end
		if (it.flags[3:1] != 3'b000) begin
			misaligned = (lvl >= LVL_1 && vpn_index(pred_va, pred_sv39, LVL_0) != '0)
				|| (lvl >= LVL_2 && vpn_index(pred_va, pred_sv39, LVL_1) != '0);
			pred_busy = 1'b0;
			if (misaligned)
				return finished(FLT_MISALIGNED, lvl, '0);
			return finished(FLT_OK, lvl, pa);
		end
		if ({1'b0, it.page} >= pred_mem) begin
			pred_busy = 1'b0;
			return finished(FLT_BEYOND_MEM, lvl, '0);
		end
		if (lvl == LVL_0) begin
			pred_busy = 1'b0;
			return finished(FLT_NO_LEAF, LVL_0, '0);
		end
		pred_level = lvl - 1'b1;
		return table_read(it.page, vpn_index(pred_va, pred_sv39, pred_level), pred_level);
	endfunction

	// Sender. A new beat is only put on the bus once the previous one has been
	// taken (or none was offered); the prediction is made at the accepting edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_walk_step(on_wire));
			if (!s_tvalid || s_tready) begin
				if (walk_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					on_wire = walk_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, on_wire.flags, on_wire.page, on_wire.va};
					s_tuser <= on_wire.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Random stalls, plus one long hold-off each time hold_req toggles;
	// the hold is counted down here so the sender keeps pushing meanwhile.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_ack <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	task automatic report_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		mismatches++;
	endtask

	// Checker: every result beat is compared with the oldest prediction.
	always @(posedge clk) begin : result_check
		ptw_result_t got;
		ptw_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = kind_t'(m_tuser[0]);
			got.req_table_page = m_tdata[43:0];
			got.req_entry = m_tdata[53:44];
			got.phys_addr = m_tdata[109:54];
			got.fault_code = fault_t'(m_tdata[112:110]);
			got.end_level = m_tdata[114:113];
			if (expected_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual kind %0d data 0x%0h",
					$time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (got.kind !== want.kind)
					report_field("kind", want.kind, got.kind);
				if (got.req_table_page !== want.req_table_page)
					report_field("req_table_page", want.req_table_page, got.req_table_page);
				if (got.req_entry !== want.req_entry)
					report_field("req_entry", want.req_entry, got.req_entry);
				if (got.phys_addr !== want.phys_addr)
					report_field("phys_addr", want.phys_addr, got.phys_addr);
				if (got.fault_code !== want.fault_code)
					report_field("fault_code", want.fault_code, got.fault_code);
				if (got.end_level !== want.end_level)
					report_field("end_level", want.end_level, got.end_level);
			end
		end
	end

	// Watchdog on forward progress of either stream.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic queue_item(input op_t op, input logic [VA_W-1:0] va,
			input logic [PAGE_W-1:0] page, input logic [FLAGS_W-1:0] flags);
		walk_item_t it;
		it.op = op;
		it.va = va;
		it.page = page;
		it.flags = flags;
		walk_items.push_back(it);
		queued_count++;
	endtask

	task automatic queue_translate(input logic [VA_W-1:0] va);
		queue_item(OP_TRANSLATE, va, PAGE_W'(rand64()), FLAGS_W'($urandom));
	endtask

	task automatic queue_response(input logic [PAGE_W-1:0] page, input logic [FLAGS_W-1:0] flags);
		queue_item(OP_RESPONSE, rand64(), page, flags);
	endtask

	// Waits until every queued beat has been accepted and every predicted result
	// has been seen. Sampling on the falling edge keeps this clear of the
	// nonblocking updates made at the rising edge.
	task automatic wait_idle();
		while (walk_items.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_WALK_MODE: pred_sv39 = value[0];
			REG_ROOT_PAGE: pred_root = value[PAGE_W-1:0];
			REG_MEM_PAGES: pred_mem = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Next-table PPN for a pointer entry: mostly inside memory so the walk
	// goes on, now and then just past the end of it.
	function automatic logic [PAGE_W-1:0] pointer_page();
		if (pred_mem == '0)
			return PAGE_W'(rand64());
		if ($urandom_range(19) == 0)
			return PAGE_W'(pred_mem + $urandom_range(3));
		return PAGE_W'(rand64() % pred_mem);
	endfunction

	// One walk with random content for the current mode: a translate, pointer
	// entries down to a randomly chosen leaf level, then the leaf. A few walks
	// carry a garbage entry, get cut short, or are followed by a stray response.
	task automatic queue_walk();
		logic [VA_W-1:0]    va;
		logic [FLAGS_W-1:0] flags;
		int top;
		int leaf;
		va = rand64();
		top = pred_sv39 ? 2 : 1;
		if (pred_sv39 && $urandom_range(9) != 0)
			va[63:39] = {25{va[38]}};
		leaf = $urandom_range(top);
		// Half the superpage walks use a properly aligned address.
		if ($urandom_range(1) == 1) begin
			if (pred_sv39) begin
				if (leaf >= 1)
					va[20:12] = '0;
				if (leaf >= 2)
					va[29:21] = '0;
			end else if (leaf >= 1) begin
				va[21:12] = '0;
			end
		end
		queue_translate(va);
		for (int lvl = top; lvl >= leaf; lvl--) begin
			flags = FLAGS_W'($urandom_range(255));
			if ($urandom_range(24) == 0)
				break;
			if ($urandom_range(11) == 0) begin
				queue_response(PAGE_W'(rand64()), flags);
			end else if (lvl > leaf || (pred_sv39 && lvl == 0 && $urandom_range(9) == 0)) begin
				flags[3:0] = 4'b0001;
				queue_response(pointer_page(), flags);
			end else begin
				flags[FLAG_V] = 1'b1;
				if (flags[3:1] == 3'b000)
					flags[3:1] = 3'($urandom_range(7, 1));
				queue_response(PAGE_W'(rand64()), flags);
			end
		end
		if ($urandom_range(19) == 0)
			queue_response(PAGE_W'(rand64()), FLAGS_W'($urandom_range(255)));
	endtask

	// One random phase: new settings written while idle, then a batch of walks.
	task automatic run_phase(input logic sv39, input logic [PAGE_W-1:0] root,
			input logic [MEM_W-1:0] mem, input int idle_pct, input int stall_pct,
			input int items, input logic with_hold);
		int target;
		wait_idle();
		write_reg(REG_WALK_MODE, CFG_DATA_W'(sv39));
		write_reg(REG_ROOT_PAGE, CFG_DATA_W'(root));
		write_reg(REG_MEM_PAGES, mem);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		target = queued_count + items;
		while (queued_count < target)
			queue_walk();
		if (with_hold) begin
			@(posedge clk);
			hold_req <= ~hold_req;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset settings: Sv32, root page 4096, 4096 pages.
		// Stray response with no walk running.
		queue_response('1, 8'hFF);
		// Only the low 32 address bits count in Sv32; then an invalid root entry.
		queue_translate('1);
		queue_response('0, 8'h00);
		// Full two-level walk; the last level accepts a bare valid entry as leaf.
		queue_translate('0);
		queue_response(44'd5, 8'h01);
		queue_response('1, 8'h01);
		// Superpage leaf with a nonzero lower VPN is misaligned.
		queue_translate(64'h0000_0000_1234_5678);
		queue_response(44'd7, 8'h03);
		// Aligned superpage leaf.
		queue_translate(64'h0000_0000_FFC0_0ABC);
		queue_response(44'hABC_DEF0_1234, 8'h0F);
		// Next table right at the end of memory.
		queue_translate(64'h5555_5555_5555_5555);
		queue_response(44'd4096, 8'h01);
		// Translate while a walk is running abandons it.
		queue_translate(64'h0000_0000_0040_1000);
		queue_translate(64'h0000_0000_8000_2000);
		wait_idle();

		write_reg(REG_WALK_MODE, CFG_DATA_W'(1));
		// Upper bits not a copy of bit 38.
		queue_translate(64'h0000_4000_0000_0000);
		// Sign-extended negative address; the last level has no leaf.
		queue_translate(64'hFFFF_FFC0_0000_0000);
		queue_response(44'd1, 8'h01);
		queue_response(44'd2, 8'h01);
		queue_response(44'd3, 8'hF1);
		// Bit 38 set with zero upper bits fails the sign check; the three responses are then strays.
		queue_translate(64'h0000_007F_FFFF_F123);
		queue_response(44'd10, 8'h01);
		queue_response(44'd11, 8'h01);
		queue_response('1, 8'h01);
		// Switch to Sv32 with an Sv39 walk waiting at its top level.
		queue_translate(64'h0000_0000_4000_0000);
		wait_idle();
		write_reg(REG_WALK_MODE, CFG_DATA_W'(0));
		queue_response(44'd12, 8'h01);
		wait_idle();

		// No memory set up, in both modes.
		write_reg(REG_MEM_PAGES, '0);
		queue_translate(rand64());
		queue_response(44'd1, 8'h01);
		wait_idle();
		write_reg(REG_WALK_MODE, CFG_DATA_W'(1));
		queue_translate('0);

		// Random phases: settings at their extremes and in between, with each
		// idling pattern; the last two include a long hold-off on the results.
		run_phase(1'b0, '1, MEM_W'(45'h1000_0000_0000), 0, 0, 160, 1'b0);
		run_phase(1'b1, '0, MEM_W'(1), 73, 0, 160, 1'b0);
		run_phase(1'b1, PAGE_W'(rand64()), MEM_W'(45'h1000_0000_0000), 0, 73, 160, 1'b0);
		run_phase(1'b0, PAGE_W'(rand64()), MEM_W'($urandom_range(65536, 1)), 11, 11, 160, 1'b1);
		run_phase(1'b1, ROOT_RESET, MEM_RESET, 0, 0, 160, 1'b1);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
